[hw/rtl/kfp_pkg.sv]
package kfp_pkg;

	localparam int W = 32;
	localparam int PW = 64;
	localparam int NW = 24;
	localparam int NUM_UOPS = 22;

	// operand codes for the shared multiplier
	localparam logic [3:0] OPD_S00 = 4'd0;
	localparam logic [3:0] OPD_S11 = 4'd1;
	localparam logic [3:0] OPD_P00 = 4'd2;
	localparam logic [3:0] OPD_P01 = 4'd3;
	localparam logic [3:0] OPD_P10 = 4'd4;
	localparam logic [3:0] OPD_P11 = 4'd5;
	localparam logic [3:0] OPD_K00 = 4'd6;
	localparam logic [3:0] OPD_K01 = 4'd7;
	localparam logic [3:0] OPD_K10 = 4'd8;
	localparam logic [3:0] OPD_K11 = 4'd9;
	localparam logic [3:0] OPD_EX  = 4'd10;
	localparam logic [3:0] OPD_EY  = 4'd11;

	// register indexes
	localparam logic [1:0] REG_Q_X = 2'd0;
	localparam logic [1:0] REG_Q_Y = 2'd1;
	localparam logic [1:0] REG_R_X = 2'd2;
	localparam logic [1:0] REG_R_Y = 2'd3;

	typedef struct packed {
		logic [3:0] a;
		logic [3:0] b;
		logic       sub;
	} uop_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
	localparam logic signed [65:0] SAT_LO = -66'sd2147483647;

	function automatic logic signed [W-1:0] sat32(input logic signed [65:0] v);
		logic signed [W-1:0] r;
		if (v > SAT_HI) begin
			r = W'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = W'(SAT_LO);
		end else begin
			r = W'(v);
		end
		return r;
	endfunction

	// product list: det, four gain numerators, estimate, new covariance
	function automatic uop_t uop_rom(input logic [4:0] idx);
		uop_t u;
		u = '{a: OPD_S00, b: OPD_S11, sub: 1'b0};
		unique case (idx)
			5'd0:  u = '{a: OPD_S00, b: OPD_S11, sub: 1'b0};
			5'd1:  u = '{a: OPD_P01, b: OPD_P10, sub: 1'b1};
			5'd2:  u = '{a: OPD_P00, b: OPD_S11, sub: 1'b0};
			5'd3:  u = '{a: OPD_P01, b: OPD_P10, sub: 1'b1};
			5'd4:  u = '{a: OPD_P01, b: OPD_S00, sub: 1'b0};
			5'd5:  u = '{a: OPD_P00, b: OPD_P01, sub: 1'b1};
			5'd6:  u = '{a: OPD_P10, b: OPD_S11, sub: 1'b0};
			5'd7:  u = '{a: OPD_P11, b: OPD_P10, sub: 1'b1};
			5'd8:  u = '{a: OPD_P11, b: OPD_S00, sub: 1'b0};
			5'd9:  u = '{a: OPD_P10, b: OPD_P01, sub: 1'b1};
			5'd10: u = '{a: OPD_K00, b: OPD_EX,  sub: 1'b0};
			5'd11: u = '{a: OPD_K01, b: OPD_EY,  sub: 1'b0};
			5'd12: u = '{a: OPD_K10, b: OPD_EX,  sub: 1'b0};
			5'd13: u = '{a: OPD_K11, b: OPD_EY,  sub: 1'b0};
			5'd14: u = '{a: OPD_K00, b: OPD_P00, sub: 1'b0};
			5'd15: u = '{a: OPD_K01, b: OPD_P10, sub: 1'b0};
			5'd16: u = '{a: OPD_K00, b: OPD_P01, sub: 1'b0};
			5'd17: u = '{a: OPD_K01, b: OPD_P11, sub: 1'b0};
			5'd18: u = '{a: OPD_K10, b: OPD_P00, sub: 1'b0};
			5'd19: u = '{a: OPD_K11, b: OPD_P10, sub: 1'b0};
			5'd20: u = '{a: OPD_K10, b: OPD_P01, sub: 1'b0};
			5'd21: u = '{a: OPD_K11, b: OPD_P11, sub: 1'b0};
			default: u = '{a: OPD_S00, b: OPD_S11, sub: 1'b0};
		endcase
		return u;
	endfunction

endpackage

[hw/rtl/kfp_div.sv]
module kfp_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [kfp_pkg::PW-1:0]       num,
	input  logic signed [kfp_pkg::PW-1:0]       den,
	output kfp_pkg::div_stat_t                  stat,
	output logic signed [kfp_pkg::W-1:0]        quot
);
	import kfp_pkg::*;

	localparam int DW = PW + FRAC_BITS;
	localparam int QB = W - 1;
	localparam int CW = (DW > PW + QB) ? DW : PW + QB;
	localparam int CNTW = $clog2(QB + 1);

	logic [PW-1:0]   un, ud;
	logic [DW-1:0]   d_full;
	logic            ovf;
	logic [PW-1:0]   rem_q, ud_q;
	logic [QB-1:0]   dlow_q, q_q;
	logic            neg_q, ovf_q, busy_q, done_q;
	logic [CNTW-1:0] cnt_q;
	logic [PW:0]     rem2;
	logic            ge;

	assign un = num[PW-1] ? PW'(-num) : PW'(num);
	assign ud = den[PW-1] ? PW'(-den) : PW'(den);
	assign d_full = {un, {FRAC_BITS{1'b0}}};
	// quotient would reach 2^31: saturate
	assign ovf = CW'(d_full) >= CW'({ud, {QB{1'b0}}});

	assign rem2 = {rem_q, dlow_q[QB-1]};
	assign ge = rem2 >= {1'b0, ud_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(QB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ud_q   <= ud;
			neg_q  <= num[PW-1] ^ den[PW-1];
			ovf_q  <= ovf;
			rem_q  <= PW'(d_full >> QB);
			dlow_q <= d_full[QB-1:0];
			q_q    <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? PW'(rem2 - {1'b0, ud_q}) : PW'(rem2);
			dlow_q <= dlow_q << 1;
			q_q    <= {q_q[QB-2:0], ge};
		end
	end

	always_comb begin
		if (ovf_q) begin
			quot = neg_q ? -W'(SAT_HI) : W'(SAT_HI);
		end else begin
			quot = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
		end
	end

	assign stat = '{busy: busy_q, done: done_q};

endmodule

[hw/rtl/kalman_filter_2d_position.sv]
// Each accepted word runs setup states PREP1 and PREP2, then 22 products on the one
// 32x32 multiplier (a MUL and an ACC state each), 11 stores, four gain divisions
// and a write-back; the divisions are skipped when det is zero.
// One word at a time: no new word is taken until the result word is written back,
// which can wait on out_stall; the multiplier/divider sequence sets the pace.
// Reset (arst_n low): P = identity, previous fix = 0, noise registers = 0.1.
module kalman_filter_2d_position #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [kfp_pkg::W-1:0]          fix_a_x,
	input  logic signed [kfp_pkg::W-1:0]          fix_a_y,
	input  logic signed [kfp_pkg::W-1:0]          fix_b_x,
	input  logic signed [kfp_pkg::W-1:0]          fix_b_y,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [kfp_pkg::W-1:0]          est_x,
	output logic signed [kfp_pkg::W-1:0]          est_y,
	input  logic                                  cfg_we,
	input  logic [1:0]                            cfg_index,
	input  logic [kfp_pkg::NW-1:0]                cfg_data
);
	import kfp_pkg::*;

	localparam logic [NW-1:0] NOISE_RESET = NW'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic signed [W-1:0] ONE = W'(64'd1 << FRAC_BITS);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PREP1 = 3'd1;
	localparam logic [2:0] ST_PREP2 = 3'd2;
	localparam logic [2:0] ST_MUL   = 3'd3;
	localparam logic [2:0] ST_ACC   = 3'd4;
	localparam logic [2:0] ST_STORE = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_WB    = 3'd7;

	logic [2:0]          state_q;
	logic [4:0]          op_q;
	logic [3:0]          qty;

	// configuration
	logic [NW-1:0]       qx_q, qy_q, rx_q, ry_q;

	// filter state
	logic signed [W-1:0] cov_q [4];
	logic signed [W-1:0] prev_x_q, prev_y_q;

	// per-word working set
	logic signed [W-1:0] ax_q, ay_q, bx_q, by_q;
	logic signed [W-1:0] px_q, py_q, ex_q, ey_q;
	logic signed [W-1:0] pp_q [4];
	logic signed [W-1:0] s00_q, s11_q;
	logic signed [W-1:0] k_q [4];
	logic signed [W-1:0] ox_q, oy_q;
	logic signed [W-1:0] est_x_q, est_y_q;
	logic                out_valid_q;
	logic signed [PW-1:0] prod_q, acc_q, det_q;

	uop_t                uop;
	logic signed [W-1:0] opa, opb;
	logic signed [PW-1:0] acc_nxt, acc_sh;
	logic                div_start;
	logic                wb_fire;
	div_stat_t           div_stat;
	logic signed [W-1:0] div_quot;

	function automatic logic signed [W-1:0] opd_mux(input logic [3:0] c,
			input logic signed [W-1:0] s00, input logic signed [W-1:0] s11,
			input logic signed [W-1:0] p00, input logic signed [W-1:0] p01,
			input logic signed [W-1:0] p10, input logic signed [W-1:0] p11,
			input logic signed [W-1:0] k00, input logic signed [W-1:0] k01,
			input logic signed [W-1:0] k10, input logic signed [W-1:0] k11,
			input logic signed [W-1:0] ex,  input logic signed [W-1:0] ey);
		logic signed [W-1:0] r;
		unique case (c)
			OPD_S00: r = s00;
			OPD_S11: r = s11;
			OPD_P00: r = p00;
			OPD_P01: r = p01;
			OPD_P10: r = p10;
			OPD_P11: r = p11;
			OPD_K00: r = k00;
			OPD_K01: r = k01;
			OPD_K10: r = k10;
			OPD_K11: r = k11;
			OPD_EX:  r = ex;
			OPD_EY:  r = ey;
			default: r = '0;
		endcase
		return r;
	endfunction

	assign uop = uop_rom(op_q);
	assign opa = opd_mux(uop.a, s00_q, s11_q, pp_q[0], pp_q[1], pp_q[2], pp_q[3],
		k_q[0], k_q[1], k_q[2], k_q[3], ex_q, ey_q);
	assign opb = opd_mux(uop.b, s00_q, s11_q, pp_q[0], pp_q[1], pp_q[2], pp_q[3],
		k_q[0], k_q[1], k_q[2], k_q[3], ex_q, ey_q);

	// even op opens a sum, odd op adds or subtracts the second product
	always_comb begin
		if (!op_q[0]) begin
			acc_nxt = prod_q;
		end else if (uop.sub) begin
			acc_nxt = acc_q - prod_q;
		end else begin
			acc_nxt = acc_q + prod_q;
		end
	end

	// floor rescale of a finished sum
	assign acc_sh = acc_q >>> FRAC_BITS;
	// quantity just finished: 0 det, 1..4 gain numerators, 5..6 estimate, 7..10 new P
	assign qty = op_q[4:1];
	assign div_start = (state_q == ST_STORE) && (qty >= 4'd1) && (qty <= 4'd4)
		&& (det_q != '0);
	// result word goes out once the previous one has left
	assign wb_fire = (state_q == ST_WB) && (!out_valid_q || !out_stall);

	assign in_stall = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign est_x = est_x_q;
	assign est_y = est_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= NOISE_RESET;
			qy_q <= NOISE_RESET;
			rx_q <= NOISE_RESET;
			ry_q <= NOISE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_Q_X: qx_q <= cfg_data;
				REG_Q_Y: qy_q <= cfg_data;
				REG_R_X: rx_q <= cfg_data;
				REG_R_Y: ry_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= '0;
			out_valid_q <= 1'b0;
			cov_q[0]    <= ONE;
			cov_q[1]    <= '0;
			cov_q[2]    <= '0;
			cov_q[3]    <= ONE;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
		end else begin
			if (wb_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_PREP1;
					end
				end
				ST_PREP1: state_q <= ST_PREP2;
				ST_PREP2: begin
					op_q    <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (op_q[0]) begin
						state_q <= ST_STORE;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_STORE: begin
					if (qty >= 4'd7) begin
						cov_q[2'(qty - 4'd7)] <= sat32(66'(pp_q[2'(qty - 4'd7)]) - 66'(acc_sh));
					end
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (op_q == 5'(NUM_UOPS - 1)) begin
						state_q <= ST_WB;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						op_q    <= op_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_WB: begin
					// wait for the previous result word to leave
					if (wb_fire) begin
						prev_x_q    <= ax_q;
						prev_y_q    <= ay_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ax_q <= fix_a_x;
				ay_q <= fix_a_y;
				bx_q <= fix_b_x;
				by_q <= fix_b_y;
			end
			ST_PREP1: begin
				px_q    <= sat32((66'(ax_q) <<< 1) - 66'(prev_x_q));
				py_q    <= sat32((66'(ay_q) <<< 1) - 66'(prev_y_q));
				pp_q[0] <= sat32(66'(cov_q[0]) + 66'($signed({1'b0, qx_q})));
				pp_q[1] <= cov_q[1];
				pp_q[2] <= cov_q[2];
				pp_q[3] <= sat32(66'(cov_q[3]) + 66'($signed({1'b0, qy_q})));
			end
			ST_PREP2: begin
				s00_q <= sat32(66'(pp_q[0]) + 66'($signed({1'b0, rx_q})));
				s11_q <= sat32(66'(pp_q[3]) + 66'($signed({1'b0, ry_q})));
				ex_q  <= sat32(66'(bx_q) - 66'(px_q));
				ey_q  <= sat32(66'(by_q) - 66'(py_q));
			end
			ST_MUL: prod_q <= opa * opb;
			ST_ACC: acc_q <= acc_nxt;
			ST_STORE: begin
				if (qty == 4'd0) begin
					det_q <= acc_q;
				end
				// singular innovation: gain stays zero
				if (qty >= 4'd1 && qty <= 4'd4 && det_q == '0) begin
					k_q[2'(qty - 4'd1)] <= '0;
				end
				if (qty == 4'd5) begin
					ox_q <= sat32(66'(px_q) + 66'(acc_sh));
				end
				if (qty == 4'd6) begin
					oy_q <= sat32(66'(py_q) + 66'(acc_sh));
				end
			end
			ST_DIV: begin
				if (div_stat.done) begin
					k_q[2'(qty - 4'd1)] <= div_quot;
				end
			end
			ST_WB: begin
				if (wb_fire) begin
					est_x_q <= ox_q;
					est_y_q <= oy_q;
				end
			end
			default: ;
		endcase
	end

	kfp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (det_q),
		.stat   (div_stat),
		.quot   (div_quot)
	);

endmodule

[hw/rtl/kfp_chk.sv]
module kfp_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [kfp_pkg::W-1:0] est_x,
	input logic signed [kfp_pkg::W-1:0] est_y
);
	import kfp_pkg::*;

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(est_x) && $stable(est_y))
		else $error("stalled result word changed");

	// one word at a time: busy right after accepting
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("accepted a word while busy");

	// no result can appear the cycle after an accept
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result word too early");

	// a new result word means the sequence has finished
	a_idle_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_stall)
		else $error("result issued while still busy");

endmodule

bind kalman_filter_2d_position kfp_chk u_kfp_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.est_x     (est_x),
	.est_y     (est_y)
);
